FILE: rtl/core/treu_pkg.sv
// ----------------------------------------------------------------------------
// treu_pkg
// Shared types and constants for the tiny risc execute unit.
// ----------------------------------------------------------------------------
package treu_pkg;

  // storage sizes
  localparam int DATA_WORDS = 4096;
  localparam int DATA_AW    = 12;
  localparam int REG_COUNT  = 16;
  localparam int REG_AW     = 4;
  localparam int XLEN       = 32;
  localparam int PC_W       = 10;
  localparam int PLEN_W     = 11;
  localparam int CFG_AW     = 3;

  // largest program length
  localparam logic [PLEN_W-1:0] PROG_WORDS = 11'd1024;

  // configuration register index, taken from paddr[2]
  localparam logic CFG_PLEN_IDX = 1'b0;

  // instruction kinds
  typedef enum logic [2:0] {
    KIND_ADDI = 3'd0,
    KIND_BEQ  = 3'd1,
    KIND_LW   = 3'd2,
    KIND_SW   = 3'd3,
    KIND_JALR = 3'd4,
    KIND_J    = 3'd5,
    KIND_HALT = 3'd6
  } kind_t;

endpackage

FILE: rtl/core/treu_ram.sv
// ----------------------------------------------------------------------------
// treu_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module treu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read returning the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tiny_risc_execute_unit_core.sv
// ----------------------------------------------------------------------------
// tiny_risc_execute_unit_core
// Executes one decoded instruction per item: register file and data memory
// live in synchronous RAMs, with operand and load forwarding.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while out_ready is high, set by the operand
//   read / execute / memory-and-writeback pipeline with full forwarding
// reset: a clearing pass over all data words zeroes the data memory and the
//   register file; in_ready stays low during it, config writes are taken
module tiny_risc_execute_unit_core (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [treu_pkg::CFG_AW-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // instruction input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         kind,
  input  logic [treu_pkg::PC_W-1:0]          cur_pc,
  input  logic [treu_pkg::REG_AW-1:0]        dest_sel,
  input  logic [treu_pkg::REG_AW-1:0]        src_a,
  input  logic [treu_pkg::REG_AW-1:0]        src_b,
  input  logic signed [treu_pkg::XLEN-1:0]   immediate,
  input  logic [treu_pkg::PC_W-1:0]          branch_target,
  input  logic                               target_found,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [treu_pkg::XLEN-1:0]   next_pc,
  output logic                               halted,
  output logic                               wrote_reg,
  output logic [treu_pkg::REG_AW-1:0]        written_reg,
  output logic signed [treu_pkg::XLEN-1:0]   written_value
);

  localparam int XLEN   = treu_pkg::XLEN;
  localparam int RAW    = treu_pkg::REG_AW;
  localparam int DAW    = treu_pkg::DATA_AW;
  localparam int PCW    = treu_pkg::PC_W;
  localparam int PLW    = treu_pkg::PLEN_W;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [PLW-1:0] program_length;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == treu_pkg::CFG_PLEN_IDX);
  assign prdata = (paddr[2] == treu_pkg::CFG_PLEN_IDX) ?
                  {{(32-PLW){1'b0}}, program_length} : 32'd0;

  // program length register, saturating at the program size
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_wr) begin
      if (pwdata[PLW-1:0] > treu_pkg::PROG_WORDS) begin
        program_length <= treu_pkg::PROG_WORDS;
      end else begin
        program_length <= pwdata[PLW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // clearing pass after reset
  // --------------------------------------------------------------------------
  logic           clearing;
  logic [DAW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == DAW'(treu_pkg::DATA_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid;
  logic adv_out, en2, en1, s2_adv, s1_adv;

  assign adv_out  = !out_valid || out_ready;
  assign en2      = !s2_valid || adv_out;
  assign en1      = !s1_valid || en2;
  assign s2_adv   = s2_valid && adv_out;
  assign s1_adv   = s1_valid && en2;
  assign in_ready = en1 && !clearing;

  // --------------------------------------------------------------------------
  // stage 1 registers
  // --------------------------------------------------------------------------
  logic [2:0]      s1_kind;
  logic [PCW-1:0]  s1_pc;
  logic [RAW-1:0]  s1_rd, s1_ra, s1_rb;
  logic [XLEN-1:0] s1_imm;
  logic [PCW-1:0]  s1_tgt;
  logic            s1_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid && in_ready;
    end
    if (in_valid && in_ready) begin
      s1_kind  <= kind;
      s1_pc    <= cur_pc;
      s1_rd    <= dest_sel;
      s1_ra    <= src_a;
      s1_rb    <= src_b;
      s1_imm   <= immediate;
      s1_tgt   <= branch_target;
      s1_found <= target_found;
    end
  end

  // --------------------------------------------------------------------------
  // register file: two copies, one per read port
  // --------------------------------------------------------------------------
  logic            rf_we;
  logic [RAW-1:0]  rf_waddr, rf_ra_addr, rf_rb_addr;
  logic [XLEN-1:0] rf_wdata, rf_a_rdata, rf_b_rdata;

  // stage 2 signals used by the write port and the forwarding
  logic            s2_wr, s2_ld, s2_st, s2_halt;
  logic [RAW-1:0]  s2_rd;
  logic [XLEN-1:0] s2_alu, s2_val, s2_next, s2_sdata;
  logic [DAW-1:0]  s2_maddr;

  assign rf_ra_addr = en1 ? src_a : s1_ra;
  assign rf_rb_addr = en1 ? src_b : s1_rb;
  assign rf_we      = clearing || (s2_adv && s2_wr);
  assign rf_waddr   = clearing ? clr_cnt[RAW-1:0] : s2_rd;
  assign rf_wdata   = clearing ? '0 : s2_val;

  treu_ram #(.WIDTH(XLEN), .DEPTH(treu_pkg::REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_ra_addr),
    .rdata (rf_a_rdata)
  );

  treu_ram #(.WIDTH(XLEN), .DEPTH(treu_pkg::REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_rb_addr),
    .rdata (rf_b_rdata)
  );

  // register write done at the last edge, not yet in the read data
  logic            wb_valid;
  logic [RAW-1:0]  wb_rd;
  logic [XLEN-1:0] wb_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= s2_adv && s2_wr;
    end
    wb_rd  <= s2_rd;
    wb_val <= s2_val;
  end

  // --------------------------------------------------------------------------
  // stage 1 operand forwarding
  // --------------------------------------------------------------------------
  logic [XLEN-1:0] op_a, op_b;

  always_comb begin
    if (s2_valid && s2_wr && (s2_rd == s1_ra)) begin
      op_a = s2_val;
    end else if (wb_valid && (wb_rd == s1_ra)) begin
      op_a = wb_val;
    end else begin
      op_a = rf_a_rdata;
    end
    if (s2_valid && s2_wr && (s2_rd == s1_rb)) begin
      op_b = s2_val;
    end else if (wb_valid && (wb_rd == s1_rb)) begin
      op_b = wb_val;
    end else begin
      op_b = rf_b_rdata;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 execute
  // --------------------------------------------------------------------------
  logic            stopped;
  logic [XLEN-1:0] ex_sum, ex_next, ex_wval, ex_link, plen_x;
  logic            ex_halt, ex_wr, ex_ld, ex_st, ex_skip;

  assign ex_sum  = op_a + s1_imm;
  assign ex_link = {{(XLEN-PCW){1'b0}}, s1_pc} + XLEN'(1);
  assign plen_x  = {{(XLEN-PLW){1'b0}}, program_length};
  assign ex_skip = stopped || ({1'b0, s1_pc} >= program_length);

  always_comb begin
    ex_next = ex_link;
    ex_halt = 1'b0;
    ex_wr   = 1'b0;
    ex_wval = ex_sum;
    ex_ld   = 1'b0;
    ex_st   = 1'b0;
    case (s1_kind)
      treu_pkg::KIND_ADDI: begin
        ex_wr = 1'b1;
      end
      treu_pkg::KIND_BEQ: begin
        if (op_a == op_b) begin
          if (s1_found) begin
            ex_next = {{(XLEN-PCW){1'b0}}, s1_tgt};
          end else begin
            ex_next = '1;
            ex_halt = 1'b1;
          end
        end
      end
      treu_pkg::KIND_LW: begin
        ex_wr = 1'b1;
        ex_ld = 1'b1;
      end
      treu_pkg::KIND_SW: begin
        ex_st = 1'b1;
      end
      treu_pkg::KIND_JALR: begin
        ex_next = ex_sum;
        ex_wr   = 1'b1;
        ex_wval = ex_link;
      end
      treu_pkg::KIND_J: begin
        if (s1_found) begin
          ex_next = {{(XLEN-PCW){1'b0}}, s1_tgt};
        end else begin
          ex_next = '1;
          ex_halt = 1'b1;
        end
      end
      treu_pkg::KIND_HALT: begin
        ex_next = plen_x;
        ex_halt = 1'b1;
      end
      default: begin
      end
    endcase
    // an instruction never writes register zero
    if (s1_rd == '0) begin
      ex_wr = 1'b0;
    end
    if (ex_next >= plen_x) begin
      ex_halt = 1'b1;
    end
    // stopped machine or pc outside the program: no effects
    if (ex_skip) begin
      ex_next = {{(XLEN-PCW){1'b0}}, s1_pc};
      ex_halt = 1'b1;
      ex_wr   = 1'b0;
      ex_ld   = 1'b0;
      ex_st   = 1'b0;
    end
  end

  // sticky halt flag, updated as an item leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
    end else if (s1_adv && ex_halt) begin
      stopped <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2 registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
    if (s1_adv) begin
      s2_next  <= ex_next;
      s2_halt  <= ex_halt;
      s2_wr    <= ex_wr;
      s2_ld    <= ex_ld;
      s2_st    <= ex_st;
      s2_rd    <= s1_rd;
      s2_alu   <= ex_wval;
      s2_maddr <= ex_sum[DAW-1:0];
      s2_sdata <= op_b;
    end
  end

  // --------------------------------------------------------------------------
  // data memory
  // --------------------------------------------------------------------------
  logic            dm_we;
  logic [DAW-1:0]  dm_waddr, dm_raddr;
  logic [XLEN-1:0] dm_wdata, dm_rdata;

  assign dm_raddr = en2 ? ex_sum[DAW-1:0] : s2_maddr;
  assign dm_we    = clearing || (s2_adv && s2_st);
  assign dm_waddr = clearing ? clr_cnt : s2_maddr;
  assign dm_wdata = clearing ? '0 : s2_sdata;

  treu_ram #(.WIDTH(XLEN), .DEPTH(treu_pkg::DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  // store done at the last edge, not yet in the read data
  logic            mb_valid;
  logic [DAW-1:0]  mb_addr;
  logic [XLEN-1:0] mb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      mb_valid <= 1'b0;
    end else begin
      mb_valid <= s2_adv && s2_st;
    end
    mb_addr <= s2_maddr;
    mb_data <= s2_sdata;
  end

  // load data with store forwarding, then the write-back value
  logic [XLEN-1:0] ld_data;

  assign ld_data = (mb_valid && (mb_addr == s2_maddr)) ? mb_data : dm_rdata;
  assign s2_val  = s2_ld ? ld_data : s2_alu;

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s2_valid;
    end
    if (s2_adv) begin
      next_pc       <= s2_next;
      halted        <= s2_halt;
      wrote_reg     <= s2_wr;
      written_reg   <= s2_wr ? s2_rd : '0;
      written_value <= s2_wr ? s2_val : '0;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_item_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!in_ready && !s1_valid && !s2_valid))
    else $error("item in flight during clearing pass");

  a_stopped_sticky : assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("halt flag dropped");

  a_halt_result_stopped : assert property (@(posedge clk) disable iff (rst)
    (out_valid && halted) |-> stopped)
    else $error("halted result without halt flag");

  a_no_write_fields_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !wrote_reg) |-> (written_reg == '0 && written_value == '0))
    else $error("write fields set without a register write");

  a_no_reg_zero_write : assert property (@(posedge clk) disable iff (rst)
    (rf_we && !clearing) |-> (rf_waddr != '0))
    else $error("write to register zero");

endmodule

FILE: dv/tiny_risc_execute_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_risc_execute_unit_checker
// Watches the config port and both item channels of the execute unit. Keeps
// its own register file, data memory, halt flag and program length. It
// predicts each result when its instruction is taken, and compares every
// result field with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module tiny_risc_execute_unit_checker (
  input  logic                             clk,
  input  logic                             rst,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [treu_pkg::CFG_AW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  input  logic [31:0]                      prdata,
  input  logic                             pready,
  // instruction channel
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [2:0]                       kind,
  input  logic [treu_pkg::PC_W-1:0]        cur_pc,
  input  logic [treu_pkg::REG_AW-1:0]      dest_sel,
  input  logic [treu_pkg::REG_AW-1:0]      src_a,
  input  logic [treu_pkg::REG_AW-1:0]      src_b,
  input  logic [treu_pkg::XLEN-1:0]        immediate,
  input  logic [treu_pkg::PC_W-1:0]        branch_target,
  input  logic                             target_found,
  // result channel
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [treu_pkg::XLEN-1:0]        next_pc,
  input  logic                             halted,
  input  logic                             wrote_reg,
  input  logic [treu_pkg::REG_AW-1:0]      written_reg,
  input  logic [treu_pkg::XLEN-1:0]        written_value,
  // status for the stimulus side
  output int                               mismatches,
  output int                               pending
);

  localparam int XLEN        = treu_pkg::XLEN;
  localparam int REG_AW      = treu_pkg::REG_AW;
  localparam int REG_COUNT   = treu_pkg::REG_COUNT;
  localparam int DATA_WORDS  = treu_pkg::DATA_WORDS;
  localparam int DATA_AW     = treu_pkg::DATA_AW;
  localparam int PC_W        = treu_pkg::PC_W;
  localparam int PLEN_W      = treu_pkg::PLEN_W;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              halted;
    logic              wrote_reg;
    logic [REG_AW-1:0] written_reg;
    logic [XLEN-1:0]   written_value;
  } outcome_t;

  // shadow machine state
  logic [XLEN-1:0]   gpr [REG_COUNT];
  logic [XLEN-1:0]   dmem [DATA_WORDS];
  logic              stopped;
  logic [PLEN_W-1:0] prog_len;

  outcome_t    expected_outcomes [$];
  int unsigned results_seen;

  // one line per mismatch, printing capped so a dead block stays readable
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] result %0d: %s is 0x%08h, want 0x%08h",
               $time, results_seen, what, got, want);
    mismatches++;
  endtask

  // executes one instruction on the shadow state
  function automatic outcome_t execute_instr(
    input logic [2:0]        op,
    input logic [PC_W-1:0]   pc,
    input logic [REG_AW-1:0] rd,
    input logic [REG_AW-1:0] ra,
    input logic [REG_AW-1:0] rb,
    input logic [XLEN-1:0]   imm,
    input logic [PC_W-1:0]   tgt,
    input logic              found
  );
    outcome_t        res;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] ea;
    logic [XLEN-1:0] nxt;
    logic [XLEN-1:0] wval;
    logic            wr;
    logic            halt_now;
    a        = (ra == '0) ? '0 : gpr[ra];
    b        = (rb == '0) ? '0 : gpr[rb];
    ea       = a + imm;
    nxt      = XLEN'(pc) + 1;
    wval     = '0;
    wr       = 1'b0;
    halt_now = 1'b0;
    res      = '0;

    // a stopped machine or a pc past the program executes nothing
    if (stopped || XLEN'(pc) >= XLEN'(prog_len)) begin
      stopped     = 1'b1;
      res.next_pc = XLEN'(pc);
      res.halted  = 1'b1;
      return res;
    end

    case (op)
      treu_pkg::KIND_ADDI: begin
        wr   = 1'b1;
        wval = ea;
      end
      treu_pkg::KIND_BEQ, treu_pkg::KIND_J: begin
        // taken jump to an unresolved label lands on -1 and stops
        if (op == treu_pkg::KIND_J || a == b) begin
          if (found) begin
            nxt = XLEN'(tgt);
          end else begin
            nxt      = '1;
            halt_now = 1'b1;
          end
        end
      end
      treu_pkg::KIND_LW: begin
        wr   = 1'b1;
        wval = dmem[ea[DATA_AW-1:0]];
      end
      treu_pkg::KIND_SW: begin
        dmem[ea[DATA_AW-1:0]] = b;
      end
      treu_pkg::KIND_JALR: begin
        nxt  = ea;
        wr   = 1'b1;
        wval = XLEN'(pc) + 1;
      end
      treu_pkg::KIND_HALT: begin
        nxt      = XLEN'(prog_len);
        halt_now = 1'b1;
      end
      default: begin
      end
    endcase

    // register zero never takes an instruction write
    if (rd == '0)
      wr = 1'b0;
    if (wr)
      gpr[rd] = wval;
    if (nxt >= XLEN'(prog_len))
      halt_now = 1'b1;
    if (halt_now)
      stopped = 1'b1;

    res.next_pc       = nxt;
    res.halted        = halt_now;
    res.wrote_reg     = wr;
    res.written_reg   = wr ? rd : '0;
    res.written_value = wr ? wval : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      stopped      = 1'b0;
      prog_len     = '0;
      results_seen = 0;
      mismatches   = 0;
      expected_outcomes.delete();
    end else begin
      // config read-back and write
      if (psel && penable && pready && paddr[2] == treu_pkg::CFG_PLEN_IDX) begin
        if (!pwrite && prdata !== 32'(prog_len))
          report_mismatch("program length read-back", prdata, 32'(prog_len));
        if (pwrite)
          prog_len = (pwdata[PLEN_W-1:0] > treu_pkg::PROG_WORDS) ? treu_pkg::PROG_WORDS
                                                                 : pwdata[PLEN_W-1:0];
      end

      // compare a finished result with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result with nothing outstanding, next_pc", next_pc, '0);
        end else begin
          want = expected_outcomes.pop_front();
          if (next_pc !== want.next_pc)
            report_mismatch("next_pc", next_pc, want.next_pc);
          if (halted !== want.halted)
            report_mismatch("halted", 32'(halted), 32'(want.halted));
          if (wrote_reg !== want.wrote_reg)
            report_mismatch("wrote_reg", 32'(wrote_reg), 32'(want.wrote_reg));
          if (written_reg !== want.written_reg)
            report_mismatch("written_reg", 32'(written_reg), 32'(want.written_reg));
          if (written_value !== want.written_value)
            report_mismatch("written_value", written_value, want.written_value);
        end
        results_seen++;
      end

      // predict the result of a taken instruction
      if (in_valid && in_ready)
        expected_outcomes.push_back(execute_instr(kind, cur_pc, dest_sel, src_a, src_b,
                                                  immediate, branch_target,
                                                  target_found));
    end
    pending = expected_outcomes.size();
  end

endmodule

FILE: dv/tb_tiny_risc_execute_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiny_risc_execute_unit_core
// Stimulus and verdict for the execute unit. It runs directed corner
// instructions, then long random well-formed streams under several program
// lengths, most with random idling on both channels. It ends by stopping the
// machine through one randomly chosen halt path and feeding it more items.
// ----------------------------------------------------------------------------
module tb_tiny_risc_execute_unit_core;

  localparam int          XLEN        = treu_pkg::XLEN;
  localparam int          PC_W        = treu_pkg::PC_W;
  localparam int          REG_AW      = treu_pkg::REG_AW;
  localparam int          PLEN_W      = treu_pkg::PLEN_W;
  localparam int          CFG_AW      = treu_pkg::CFG_AW;
  localparam int          LATENCY     = 2;
  localparam int          STALL_LIMIT = 20000;
  localparam logic [2:0]  KIND_UNDEF  = 3'd7;
  localparam logic [CFG_AW-1:0] PLEN_ADDR = {treu_pkg::CFG_PLEN_IDX, 2'b00};

  typedef struct packed {
    logic [2:0]        op;
    logic [PC_W-1:0]   pc;
    logic [REG_AW-1:0] rd, ra, rb;
    logic [XLEN-1:0]   imm;
    logic [PC_W-1:0]   tgt;
    logic              found;
  } instr_t;

  typedef enum int {
    BY_HALT_OP,
    BY_J_UNRESOLVED,
    BY_BEQ_UNRESOLVED,
    BY_JALR_RANGE,
    BY_FALL_OFF_END,
    BY_PC_OUTSIDE
  } halt_cause_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_AW-1:0]        paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               kind = '0;
  logic [PC_W-1:0]          cur_pc = '0;
  logic [REG_AW-1:0]        dest_sel = '0;
  logic [REG_AW-1:0]        src_a = '0;
  logic [REG_AW-1:0]        src_b = '0;
  logic signed [XLEN-1:0]   immediate = '0;
  logic [PC_W-1:0]          branch_target = '0;
  logic                     target_found = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [XLEN-1:0]   next_pc;
  logic                     halted;
  logic                     wrote_reg;
  logic [REG_AW-1:0]        written_reg;
  logic signed [XLEN-1:0]   written_value;

  int          mismatches;
  int          pending;
  logic        steady = 1'b0;
  int unsigned sent_count = 0;
  int unsigned stall_cycles = 0;

  tiny_risc_execute_unit_core dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .cur_pc        (cur_pc),
    .dest_sel      (dest_sel),
    .src_a         (src_a),
    .src_b         (src_b),
    .immediate     (immediate),
    .branch_target (branch_target),
    .target_found  (target_found),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_pc       (next_pc),
    .halted        (halted),
    .wrote_reg     (wrote_reg),
    .written_reg   (written_reg),
    .written_value (written_value)
  );

  tiny_risc_execute_unit_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .cur_pc        (cur_pc),
    .dest_sel      (dest_sel),
    .src_a         (src_a),
    .src_b         (src_b),
    .immediate     (immediate),
    .branch_target (branch_target),
    .target_found  (target_found),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_pc       (next_pc),
    .halted        (halted),
    .wrote_reg     (wrote_reg),
    .written_reg   (written_reg),
    .written_value (written_value),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // result side backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tiny_risc_execute_unit_core test failed");
        $finish;
      end
    end
  end

  // one config access: setup then access phase
  task automatic apb_access(input logic wr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PLEN_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_prog_len(input logic [PLEN_W-1:0] len);
    apb_access(1'b1, 32'(len));
    apb_access(1'b0, '0);
  endtask

  // offer one item, first idling at random unless steady
  task automatic send_instr(input instr_t it);
    if (!steady) begin
      while ($urandom_range(0, 99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    kind          <= it.op;
    cur_pc        <= it.pc;
    dest_sel      <= it.rd;
    src_a         <= it.ra;
    src_b         <= it.rb;
    immediate     <= it.imm;
    branch_target <= it.tgt;
    target_found  <= it.found;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // stop sending until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic instr_t make_instr(
    input logic [2:0] op, input int unsigned pc, input int unsigned rd,
    input int unsigned ra, input int unsigned rb, input logic [31:0] imm,
    input int unsigned tgt, input logic found);
    instr_t it;
    it.op    = op;
    it.pc    = PC_W'(pc);
    it.rd    = REG_AW'(rd);
    it.ra    = REG_AW'(ra);
    it.rb    = REG_AW'(rb);
    it.imm   = imm;
    it.tgt   = PC_W'(tgt);
    it.found = found;
    return it;
  endfunction

  // every field random, any kind
  function automatic instr_t noise_instr();
    instr_t it;
    it.op    = 3'($urandom);
    it.pc    = PC_W'($urandom);
    it.rd    = REG_AW'($urandom);
    it.ra    = REG_AW'($urandom);
    it.rb    = REG_AW'($urandom);
    it.imm   = $urandom;
    it.tgt   = PC_W'($urandom);
    it.found = 1'($urandom);
    return it;
  endfunction

  // random instruction that keeps the machine running
  function automatic instr_t random_instr(input int unsigned plen);
    instr_t it;
    int unsigned k;
    it       = noise_instr();
    k        = $urandom_range(0, 6);
    it.op    = (k == 6) ? KIND_UNDEF : 3'(k);
    it.pc    = PC_W'($urandom_range(0, plen - 2));
    it.tgt   = PC_W'($urandom_range(0, plen - 1));
    it.found = 1'b1;
    case (it.op)
      treu_pkg::KIND_ADDI: begin
        if ($urandom_range(0, 3) == 0)
          it.imm = 32'($urandom_range(0, 15)) - 32'd8;
      end
      treu_pkg::KIND_BEQ: begin
        if ($urandom_range(0, 2) == 0)
          it.rb = it.ra;
      end
      treu_pkg::KIND_LW, treu_pkg::KIND_SW: begin
        // mostly a small window of addresses so loads hit earlier stores
        if ($urandom_range(0, 9) < 6) begin
          it.ra  = '0;
          it.imm = ($urandom & 32'hFFFF_F000) | 32'($urandom_range(0, 31));
        end
      end
      treu_pkg::KIND_JALR: begin
        it.ra  = '0;
        it.imm = 32'($urandom_range(0, plen - 1));
      end
      treu_pkg::KIND_J: begin
      end
      default: begin
        it.tgt   = PC_W'($urandom);
        it.found = 1'($urandom);
      end
    endcase
    return it;
  endfunction

  task automatic run_random(input int n, input int unsigned plen, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at)
        drain();
      send_instr(random_instr(plen));
    end
  endtask

  // main sequence
  initial begin
    instr_t      it;
    int unsigned mid_plen;
    halt_cause_t cause;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // oversized length saturates to the largest program
    write_prog_len(11'h7FF);

    // directed corners on a freshly cleared machine
    send_instr(make_instr(treu_pkg::KIND_ADDI, 0, 1, 0, 0, 32'h7FFF_FFFF, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_ADDI, 1, 2, 1, 0, 32'd1, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_ADDI, 2, 3, 0, 0, 32'hFFFF_FFFF, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_ADDI, 3, 0, 1, 0, 32'd5, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_ADDI, 4, 15, 0, 0, 32'd100, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_SW, 5, 0, 3, 1, 32'd1, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_LW, 6, 4, 0, 0, 32'd0, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_SW, 7, 0, 2, 15, 32'h0000_0FFF, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_LW, 8, 5, 0, 0, 32'hFFFF_FFFF, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_LW, 9, 6, 0, 0, 32'd77, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_BEQ, 10, 0, 1, 1, 32'd0, 1023, 1'b1));
    send_instr(make_instr(treu_pkg::KIND_BEQ, 11, 0, 1, 0, 32'd0, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_BEQ, 12, 0, 1, 2, 32'd0, 5, 1'b1));
    send_instr(make_instr(treu_pkg::KIND_BEQ, 13, 0, 0, 6, 32'd0, 0, 1'b1));
    send_instr(make_instr(treu_pkg::KIND_J, 14, 0, 0, 0, 32'd0, 0, 1'b1));
    send_instr(make_instr(treu_pkg::KIND_J, 15, 0, 0, 0, 32'd0, 1023, 1'b1));
    send_instr(make_instr(treu_pkg::KIND_JALR, 1022, 7, 15, 0, 32'hFFFF_FFCE, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_JALR, 16, 0, 0, 0, 32'd1023, 0, 1'b0));
    send_instr(make_instr(KIND_UNDEF, 1022, 15, 15, 15, 32'hFFFF_FFFF, 1023, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_ADDI, 17, 15, 15, 0, 32'h8000_0000, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_LW, 18, 0, 0, 0, 32'd0, 0, 1'b0));
    // store then dependent load then dependent add, one after another
    send_instr(make_instr(treu_pkg::KIND_SW, 19, 0, 7, 7, 32'hFFFF_F000, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_LW, 20, 8, 7, 0, 32'hFFFF_F000, 0, 1'b0));
    send_instr(make_instr(treu_pkg::KIND_ADDI, 21, 9, 8, 0, 32'd1, 0, 1'b0));

    // random streams, full program, with a full drain midway
    run_random(150, 1024, 75);
    drain();

    // random length, no idling on either side
    mid_plen = $urandom_range(3, 1023);
    write_prog_len(PLEN_W'(mid_plen));
    steady <= 1'b1;
    run_random(150, mid_plen, -1);
    drain();
    steady <= 1'b0;

    // shortest program that still runs
    write_prog_len(11'd2);
    run_random(50, 2, -1);
    drain();

    write_prog_len(treu_pkg::PROG_WORDS);
    run_random(200, 1024, -1);
    drain();

    // stop the machine through one halt path
    cause = halt_cause_t'($urandom_range(0, 5));
    it    = noise_instr();
    it.pc = PC_W'($urandom_range(0, 1022));
    case (cause)
      BY_HALT_OP: begin
        it.op = treu_pkg::KIND_HALT;
      end
      BY_J_UNRESOLVED: begin
        it.op    = treu_pkg::KIND_J;
        it.found = 1'b0;
      end
      BY_BEQ_UNRESOLVED: begin
        it.op    = treu_pkg::KIND_BEQ;
        it.rb    = it.ra;
        it.found = 1'b0;
      end
      BY_JALR_RANGE: begin
        it.op  = treu_pkg::KIND_JALR;
        it.ra  = '0;
        it.imm = $urandom | 32'h8000_0000;
      end
      BY_FALL_OFF_END: begin
        it.op = treu_pkg::KIND_SW;
        it.pc = PC_W'(1023);
      end
      default: begin
        write_prog_len(11'd0);
      end
    endcase
    send_instr(it);

    // a stopped machine ignores whatever follows
    for (int i = 0; i < 4; i++)
      send_instr(noise_instr());
    drain();
    write_prog_len(11'd0);
    for (int i = 0; i < 2; i++)
      send_instr(noise_instr());
    drain();

    $display("ran %0d instructions under program lengths 1024, %0d, 2 and 0",
             sent_count, mid_plen);
    $display("machine stopped via %s, then kept receiving items", cause.name());
    if (mismatches == 0) begin
      $display("tiny_risc_execute_unit_core test passed");
    end else begin
      $display("tiny_risc_execute_unit_core test failed");
    end
    $finish;
  end

endmodule

FILE: tiny_risc_execute_unit_core.f
rtl/core/treu_pkg.sv
rtl/core/treu_ram.sv
rtl/core/tiny_risc_execute_unit_core.sv
dv/tiny_risc_execute_unit_checker.sv
dv/tb_tiny_risc_execute_unit_core.sv
